// ===== design/sit_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sit_pkg
// Types, widths and helpers shared by the segment intersection test core.
// ----------------------------------------------------------------------------
package sit_pkg;

    // width of an input field on the port, and of a coordinate inside the core
    localparam int FIELD_W    = 16;
    localparam int COORD_BITS = 16;

    localparam int DIFF_W = COORD_BITS + 1;  // difference of two coordinates
    localparam int PROD_W = 2 * DIFF_W;      // product of two differences
    localparam int SUM_W  = PROD_W + 1;      // difference of two products

    localparam logic [2:0] OUT_DEGENERATE    = 3'd0;
    localparam logic [2:0] OUT_MISS          = 3'd1;
    localparam logic [2:0] OUT_CROSS         = 3'd2;
    localparam logic [2:0] OUT_PARALLEL      = 3'd3;
    localparam logic [2:0] OUT_COLL_OVERLAP  = 3'd4;
    localparam logic [2:0] OUT_COLL_APART    = 3'd5;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [SUM_W-1:0]      t_sum;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a_start_x;
        logic signed [FIELD_W-1:0] a_start_y;
        logic signed [FIELD_W-1:0] a_end_x;
        logic signed [FIELD_W-1:0] a_end_y;
        logic signed [FIELD_W-1:0] b_start_x;
        logic signed [FIELD_W-1:0] b_start_y;
        logic signed [FIELD_W-1:0] b_end_x;
        logic signed [FIELD_W-1:0] b_end_y;
    } t_seg_in;

    typedef struct packed {
        logic       hit;
        logic [2:0] outcome;
    } t_seg_out;

    // cross products ready for the final decision
    typedef struct packed {
        t_sum den;
        t_sum alpha;
        t_sum beta;
        t_sum col;
        logic degen;
        logic x_ovl;
        logic y_ovl;
    } t_s3;

    // low COORD_BITS bits of the zero-extended field, as a signed coordinate
    function automatic t_coord coord_of(input logic [FIELD_W-1:0] f);
        logic [31:0] z;
        z = {{(32-FIELD_W){1'b0}}, f};
        return $signed(z[COORD_BITS-1:0]);
    endfunction

    function automatic t_diff sub_c(input t_coord p, input t_coord q);
        return $signed({p[COORD_BITS-1], p}) - $signed({q[COORD_BITS-1], q});
    endfunction

    // exact signed product of two differences
    function automatic t_prod mul_d(input t_diff p, input t_diff q);
        return t_prod'(p) * t_prod'(q);
    endfunction

    function automatic t_sum sub_p(input t_prod p, input t_prod q);
        return $signed({p[PROD_W-1], p}) - $signed({q[PROD_W-1], q});
    endfunction

    // v in the closed range spanned by p and q
    function automatic logic between(input t_coord v, input t_coord p, input t_coord q);
        return (v >= p && v <= q) || (v <= p && v >= q);
    endfunction

endpackage
`default_nettype wire

// ===== design/sit_decide.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sit_decide
// Final classification from the denominator, numerators and collinearity term.
// ----------------------------------------------------------------------------
module sit_decide (
    input  sit_pkg::t_s3      i_s3,
    output sit_pkg::t_seg_out o_res
);
    import sit_pkg::*;

    logic den_neg, den_zero, col_zero;
    logic alpha_ok, beta_ok;

    assign den_neg  = i_s3.den[SUM_W-1];
    assign den_zero = (i_s3.den == '0);
    assign col_zero = (i_s3.col == '0);

    // numerator must sit between 0 and den, on den's side of zero
    always_comb begin
        if (!den_neg) begin
            alpha_ok = !(i_s3.alpha < 0 || i_s3.alpha > i_s3.den);
            beta_ok  = !(i_s3.beta  < 0 || i_s3.beta  > i_s3.den);
        end else begin
            alpha_ok = !(i_s3.alpha > 0 || i_s3.alpha < i_s3.den);
            beta_ok  = !(i_s3.beta  > 0 || i_s3.beta  < i_s3.den);
        end
    end

    always_comb begin
        o_res.hit     = 1'b0;
        o_res.outcome = OUT_DEGENERATE;
        if (i_s3.degen) begin
            o_res.outcome = OUT_DEGENERATE;
        end else if (!den_zero) begin
            if (alpha_ok && beta_ok) begin
                o_res.hit     = 1'b1;
                o_res.outcome = OUT_CROSS;
            end else begin
                o_res.outcome = OUT_MISS;
            end
        end else if (!col_zero) begin
            o_res.outcome = OUT_PARALLEL;
        end else if (i_s3.x_ovl && i_s3.y_ovl) begin
            o_res.hit     = 1'b1;
            o_res.outcome = OUT_COLL_OVERLAP;
        end else begin
            o_res.outcome = OUT_COLL_APART;
        end
    end

endmodule
`default_nettype wire

// ===== design/segment_intersection_test_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Pipelined exact test of whether two line segments intersect.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / i_data / o_stall. A beat carries the eight
//   endpoint coordinates of segments A and B (Q12.4, two's complement).
//   Output channel: o_valid / o_data / i_stall. One beat per input beat,
//   in order, with hit and an outcome code.
//   Four register stages: coordinate differences and overlap compares,
//   eight 17x17 products, product differences, then the decision into the
//   output register. While o_stall is low one beat enters per cycle;
//   throughput is 1 beat/cycle, since each stage takes a new beat every cycle.
//   Each stage holds its beat while the one after it is full and stalled;
//   bubbles are squeezed out, so o_stall rises only once all four stages
//   hold a beat and i_stall is high.
//   Reset (synchronous, active low) clears every stage valid; no beat is
//   in flight afterwards. There is no other state.
// ----------------------------------------------------------------------------
module segment_intersection_test_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  sit_pkg::t_seg_in  i_data,
    output logic              o_stall,
    output logic              o_valid,
    output sit_pkg::t_seg_out o_data,
    input  wire               i_stall
);
    import sit_pkg::*;

    typedef struct packed {
        t_diff ax;
        t_diff ay;
        t_diff bx;
        t_diff by;
        t_diff cx;
        t_diff cy;
        t_diff dx;
        t_diff dy;
        logic  degen;
        logic  x_ovl;
        logic  y_ovl;
    } t_s1;

    typedef struct packed {
        t_prod ay_bx;
        t_prod ax_by;
        t_prod by_cx;
        t_prod bx_cy;
        t_prod ax_cy;
        t_prod ay_cx;
        t_prod ax_dy;
        t_prod dx_ay;
        logic  degen;
        logic  x_ovl;
        logic  y_ovl;
    } t_s2;

    logic     r_v1, r_v2, r_v3, r_v4;
    t_s1      r_s1, n_s1;
    t_s2      r_s2, n_s2;
    t_s3      r_s3, n_s3;
    t_seg_out r_out, n_out;
    logic     rdy1, rdy2, rdy3, rdy4;

    t_coord x1, y1, x2, y2, x3, y3, x4, y4;

    assign rdy4 = !r_v4 || !i_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_stall = !rdy1;
    assign o_valid = r_v4;
    assign o_data  = r_out;

    // stage 1: differences, zero-length check, collinear range compares
    always_comb begin
        x1 = coord_of(i_data.a_start_x);
        y1 = coord_of(i_data.a_start_y);
        x2 = coord_of(i_data.a_end_x);
        y2 = coord_of(i_data.a_end_y);
        x3 = coord_of(i_data.b_start_x);
        y3 = coord_of(i_data.b_start_y);
        x4 = coord_of(i_data.b_end_x);
        y4 = coord_of(i_data.b_end_y);
        n_s1.ax    = sub_c(x2, x1);
        n_s1.ay    = sub_c(y2, y1);
        n_s1.bx    = sub_c(x3, x4);
        n_s1.by    = sub_c(y3, y4);
        n_s1.cx    = sub_c(x1, x3);
        n_s1.cy    = sub_c(y1, y3);
        n_s1.dx    = sub_c(x3, x1);
        n_s1.dy    = sub_c(y3, y1);
        n_s1.degen = (x1 == x2 && y1 == y2) || (x3 == x4 && y3 == y4);
        // b_end is deliberately not tested against A's range
        n_s1.x_ovl = between(x1, x3, x4) || between(x2, x3, x4) || between(x3, x1, x2);
        n_s1.y_ovl = between(y1, y3, y4) || between(y2, y3, y4) || between(y3, y1, y2);
    end

    // stage 2: products
    always_comb begin
        n_s2.ay_bx = mul_d(r_s1.ay, r_s1.bx);
        n_s2.ax_by = mul_d(r_s1.ax, r_s1.by);
        n_s2.by_cx = mul_d(r_s1.by, r_s1.cx);
        n_s2.bx_cy = mul_d(r_s1.bx, r_s1.cy);
        n_s2.ax_cy = mul_d(r_s1.ax, r_s1.cy);
        n_s2.ay_cx = mul_d(r_s1.ay, r_s1.cx);
        n_s2.ax_dy = mul_d(r_s1.ax, r_s1.dy);
        n_s2.dx_ay = mul_d(r_s1.dx, r_s1.ay);
        n_s2.degen = r_s1.degen;
        n_s2.x_ovl = r_s1.x_ovl;
        n_s2.y_ovl = r_s1.y_ovl;
    end

    // stage 3: cross products
    always_comb begin
        n_s3.den   = sub_p(r_s2.ay_bx, r_s2.ax_by);
        n_s3.alpha = sub_p(r_s2.by_cx, r_s2.bx_cy);
        n_s3.beta  = sub_p(r_s2.ax_cy, r_s2.ay_cx);
        n_s3.col   = sub_p(r_s2.ax_dy, r_s2.dx_ay);
        n_s3.degen = r_s2.degen;
        n_s3.x_ovl = r_s2.x_ovl;
        n_s3.y_ovl = r_s2.y_ovl;
    end

    // stage 4: decision into the output register
    sit_decide u_decide (
        .i_s3  (r_s3),
        .o_res (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) r_s1  <= n_s1;
        if (rdy2 && r_v1)    r_s2  <= n_s2;
        if (rdy3 && r_v2)    r_s3  <= n_s3;
        if (rdy4 && r_v3)    r_out <= n_out;
    end

`ifndef SYNTH
    // hit is set exactly for the two intersecting outcomes
    a_hit_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.hit == (o_data.outcome == OUT_CROSS ||
                                    o_data.outcome == OUT_COLL_OVERLAP)))
        else $error("hit does not match outcome");

    // upstream is held off only when every stage holds a beat
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("stall raised with a bubble in the pipeline");

    // a free receiver never backs up into the input
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("stall raised while output is free");
`endif

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for segment_intersection_test_core. A table of directed segment
// pairs is followed by random pairs biased toward the parallel, collinear
// and degenerate cases. Every accepted result beat is compared with a typed-in
// verdict or one computed by an exact integer predictor in the bench.
// ----------------------------------------------------------------------------
module tb;
    import sit_pkg::*;

    localparam int IDLE_LIMIT   = 2000;  // cycles without any accepted beat
    localparam int PIPE_LAT     = 4;
    localparam int RANDOM_BEATS = 2000;
    localparam int N_PROBES     = 19;

    typedef struct {
        t_seg_in  seg;
        bit       known;   // res typed in, not predicted
        t_seg_out res;
    } t_probe_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    t_seg_in   i_data;
    logic      o_stall;
    logic      o_valid;
    t_seg_out  o_data;
    logic      i_stall;

    t_seg_out   pending_verdicts[$];
    t_probe_row probe_rows[N_PROBES];
    int         err_count = 0;
    int         idle_cycles = 0;
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         beat_known;
    t_seg_out   beat_res;

    segment_intersection_test_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint coord_val(input logic [FIELD_W-1:0] f);
        logic [COORD_BITS-1:0] low;
        low = f[COORD_BITS-1:0];
        return longint'($signed(low));
    endfunction

    function automatic bit in_span(input longint v, input longint p, input longint q);
        return (v >= p && v <= q) || (v <= p && v >= q);
    endfunction

    // numerator within 0..den, on den's side of zero
    function automatic bit num_inside(input longint num, input longint den);
        if (den > 0) return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    function automatic t_seg_out predict_verdict(input t_seg_in s);
        longint   x1, y1, x2, y2, x3, y3, x4, y4;
        longint   ax, ay, bx, by, cx, cy;
        longint   den, alpha, beta, col;
        bit       xo, yo;
        t_seg_out r;
        x1 = coord_val(s.a_start_x);  y1 = coord_val(s.a_start_y);
        x2 = coord_val(s.a_end_x);    y2 = coord_val(s.a_end_y);
        x3 = coord_val(s.b_start_x);  y3 = coord_val(s.b_start_y);
        x4 = coord_val(s.b_end_x);    y4 = coord_val(s.b_end_y);
        r.hit = 1'b0;
        if ((x1 == x2 && y1 == y2) || (x3 == x4 && y3 == y4)) begin
            r.outcome = OUT_DEGENERATE;
        end else begin
            ax = x2 - x1;  ay = y2 - y1;
            bx = x3 - x4;  by = y3 - y4;
            cx = x1 - x3;  cy = y1 - y3;
            den = ay * bx - ax * by;
            if (den != 0) begin
                alpha = by * cx - bx * cy;
                beta  = ax * cy - ay * cx;
                if (num_inside(alpha, den) && num_inside(beta, den)) begin
                    r.hit     = 1'b1;
                    r.outcome = OUT_CROSS;
                end else begin
                    r.outcome = OUT_MISS;
                end
            end else begin
                col = ax * (y3 - y1) - (x3 - x1) * ay;
                if (col != 0) begin
                    r.outcome = OUT_PARALLEL;
                end else begin
                    // b_end is deliberately not tested against A's range
                    xo = in_span(x1, x3, x4) || in_span(x2, x3, x4) || in_span(x3, x1, x2);
                    yo = in_span(y1, y3, y4) || in_span(y2, y3, y4) || in_span(y3, y1, y2);
                    if (xo && yo) begin
                        r.hit     = 1'b1;
                        r.outcome = OUT_COLL_OVERLAP;
                    end else begin
                        r.outcome = OUT_COLL_APART;
                    end
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_seg_in pack_seg(input int c[8]);
        t_seg_in s;
        s.a_start_x = 16'(c[0]);  s.a_start_y = 16'(c[1]);
        s.a_end_x   = 16'(c[2]);  s.a_end_y   = 16'(c[3]);
        s.b_start_x = 16'(c[4]);  s.b_start_y = 16'(c[5]);
        s.b_end_x   = 16'(c[6]);  s.b_end_y   = 16'(c[7]);
        return s;
    endfunction

    function automatic t_seg_in rand_seg();
        int      c[8];
        int      ext[6];
        int      kind, px, py, qx, qy, dx, dy, k;
        t_seg_in s;
        ext  = '{-32768, 32767, 0, -1, 1, 0};
        kind = $urandom_range(99);
        if (kind < 30) begin
            s = {$urandom(), $urandom(), $urandom(), $urandom()};
            return s;
        end else if (kind < 55) begin
            // coarse grid: many parallels, shared lines and touches
            foreach (c[i]) c[i] = (int'($urandom_range(6)) - 3) * 16;
        end else if (kind < 85) begin
            // all four points on one line (collinear), or B shifted off it (parallel)
            px = int'($urandom_range(4000)) - 2000;
            py = int'($urandom_range(4000)) - 2000;
            dx = int'($urandom_range(128)) - 64;
            dy = int'($urandom_range(128)) - 64;
            case ($urandom_range(3))
                0: dx = 0;
                1: dy = 0;
                default: ;
            endcase
            qx = px;
            qy = py;
            if (kind >= 75) begin
                qx = px + int'($urandom_range(64)) - 32;
                qy = py + int'($urandom_range(64)) - 32;
            end
            for (int i = 0; i < 4; i++) begin
                k = int'($urandom_range(16)) - 8;
                c[2*i]   = (i < 2 ? px : qx) + k * dx;
                c[2*i+1] = (i < 2 ? py : qy) + k * dy;
            end
        end else if (kind < 93) begin
            foreach (c[i]) c[i] = int'($urandom_range(65535)) - 32768;
            case ($urandom_range(2))
                0: begin c[2] = c[0]; c[3] = c[1]; end
                1: begin c[6] = c[4]; c[7] = c[5]; end
                default: begin
                    // one coordinate equal only: not degenerate
                    c[2] = c[0];
                    c[7] = c[5];
                end
            endcase
        end else begin
            foreach (c[i]) begin
                k = $urandom_range(5);
                c[i] = (k == 5) ? int'($urandom_range(65535)) - 32768 : ext[k];
            end
        end
        return pack_seg(c);
    endfunction

    task automatic send_beat(input t_seg_in d, input bit known, input t_seg_out res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_data     <= d;
        beat_known = known;
        beat_res   = res;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // hold off the sender until every outstanding verdict has returned
    task automatic drain_all();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) send_beat(rand_seg(), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // receiver stall, result checking, watchdog
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_seg_out want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_verdicts.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected beat hit=%0d outcome=%0d", $realtime,
                             o_data.hit, o_data.outcome);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_data.hit !== want.hit) begin
                        err_count++;
                        $display("%0t: hit mismatch exp=%0d got=%0d", $realtime,
                                 want.hit, o_data.hit);
                    end
                    if (o_data.outcome !== want.outcome) begin
                        err_count++;
                        $display("%0t: outcome mismatch exp=%0d got=%0d", $realtime,
                                 want.outcome, o_data.outcome);
                    end
                end
            end
            if (i_valid && !o_stall)
                pending_verdicts.push_back(beat_known ? beat_res : predict_verdict(i_data));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL segment_intersection_test_core");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        send_idle_pct  = 9;
        recv_stall_pct = 58;
        beat_known     = 1'b0;
        beat_res       = '0;

        probe_rows = '{
            '{pack_seg('{0, 0, 0, 0, 0, 0, 0, 0}), 1'b1, '{1'b0, OUT_DEGENERATE}},
            '{pack_seg('{32767, 32767, 32767, 32767, 0, 0, 16, 16}), 1'b1,
              '{1'b0, OUT_DEGENERATE}},
            '{pack_seg('{0, 0, 16, 16, -32768, -32768, -32768, -32768}), 1'b1,
              '{1'b0, OUT_DEGENERATE}},
            '{pack_seg('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}), 1'b1,
              '{1'b1, OUT_CROSS}},
            '{pack_seg('{0, 0, 16, 0, 32, -16, 32, 16}), 1'b1, '{1'b0, OUT_MISS}},
            '{pack_seg('{0, 0, 16, 0, 0, 16, 16, 16}), 1'b1, '{1'b0, OUT_PARALLEL}},
            '{pack_seg('{0, 0, 32, 0, 16, 0, 48, 0}), 1'b1, '{1'b1, OUT_COLL_OVERLAP}},
            '{pack_seg('{0, 0, 16, 0, 32, 0, 48, 0}), 1'b1, '{1'b0, OUT_COLL_APART}},
            // touching endpoints, T junction, reversed order (den of other sign)
            '{pack_seg('{0, 0, 16, 16, 16, 16, 32, 0}), 1'b0, '0},
            '{pack_seg('{0, 0, 32, 0, 16, 0, 16, 16}), 1'b0, '0},
            '{pack_seg('{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767}), 1'b0, '0},
            // collinear: vertical, B covers A, end to end, diagonal apart
            '{pack_seg('{0, 0, 0, 32, 0, 16, 0, 48}), 1'b0, '0},
            '{pack_seg('{8, 0, 16, 0, 0, 0, 32, 0}), 1'b0, '0},
            '{pack_seg('{0, 0, 16, 0, 16, 0, 32, 0}), 1'b0, '0},
            '{pack_seg('{0, 0, 16, 16, 32, 32, 48, 48}), 1'b0, '0},
            '{pack_seg('{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767}), 1'b0, '0},
            '{pack_seg('{-32768, 0, 32767, 0, 32767, 0, -32768, 0}), 1'b0, '0},
            '{pack_seg('{-32768, -32768, 32767, 32766, -32768, -32767, 32767, 32767}), 1'b0, '0},
            '{pack_seg('{-1, -1, 0, 0, 0, -1, -1, 0}), 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (probe_rows[i])
            send_beat(probe_rows[i].seg, probe_rows[i].known, probe_rows[i].res);
        run_random(RANDOM_BEATS / 3);
        drain_all();

        send_idle_pct  = 58;
        recv_stall_pct = 9;
        run_random(RANDOM_BEATS / 3);
        drain_all();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));
        drain_all();

        repeat (2 * PIPE_LAT) @(posedge i_clk);
        if (err_count == 0 && pending_verdicts.size() == 0) begin
            $display("PASS segment_intersection_test_core");
        end else begin
            $display("FAIL segment_intersection_test_core");
        end
        $finish;
    end

endmodule

// ===== segment_intersection_test_core.f =====
design/sit_pkg.sv
design/sit_decide.sv
design/segment_intersection_test_core.sv
bench/tb.sv
